@@ hdl/pvpc_pkg.sv @@
// Shared types, constants and helper functions of the voxel pore classifier.
`timescale 1ns / 1ps
`default_nettype none

package pvpc_pkg;

  // Volume geometry; voxels sit at a fixed stride set by these maxima.
  localparam int unsigned MAX_ROWS   = 64;
  localparam int unsigned MAX_COLS   = 64;
  localparam int unsigned MAX_SLICES = 64;

  localparam int unsigned COORD_W   = 6;
  localparam int unsigned SIZE_W    = 7;
  localparam int unsigned MASK_W    = 8;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned CLASS_W   = 2;
  localparam int unsigned COUNT_W   = 19;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned STORE_DEPTH = MAX_ROWS * MAX_COLS * MAX_SLICES;
  localparam int unsigned ADDR_W    = $clog2(STORE_DEPTH);
  localparam int unsigned WINDOW_CELLS = 8;
  localparam int unsigned WIN_W     = $clog2(WINDOW_CELLS);
  localparam int unsigned WCOUNT_W  = $clog2(WINDOW_CELLS + 1);
  localparam int unsigned STEP_W    = $clog2(COORD_W);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICES = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD     = 2'd0,
    KIND_CLASSIFY = 2'd1,
    KIND_CLEAR    = 2'd2
  } kind_e;

  typedef enum logic [CLASS_W-1:0] {
    CLS_SOLID     = 2'd0,
    CLS_INTERFACE = 2'd1,
    CLS_PORE      = 2'd2
  } class_e;

  // Request to and response from the shared remainder unit.
  typedef struct packed {
    logic                start;
    logic [COORD_W-1:0]  dividend;
    logic [SIZE_W-1:0]   divisor;
  } mod_req_t;

  typedef struct packed {
    logic                done;
    logic [COORD_W-1:0]  rem;
  } mod_rsp_t;

  // A size of zero acts as one, and a size above the maximum acts as the maximum.
  function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v, int unsigned maxv);
    logic [SIZE_W-1:0] res;
    if (v == '0) begin
      res = SIZE_W'(1);
    end else if (32'(v) > maxv) begin
      res = SIZE_W'(maxv);
    end else begin
      res = v;
    end
    return res;
  endfunction

  // Periodic lower neighbor of a coordinate that is already below size.
  function automatic logic [COORD_W-1:0] lower_coord(logic [COORD_W-1:0] x,
                                                     logic [SIZE_W-1:0] size);
    logic [COORD_W-1:0] res;
    if (x == '0) begin
      res = COORD_W'(size - SIZE_W'(1));
    end else begin
      res = x - COORD_W'(1);
    end
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] voxel_addr(logic [COORD_W-1:0] r,
                                                   logic [COORD_W-1:0] c,
                                                   logic [COORD_W-1:0] s);
    return (ADDR_W'(s) * ADDR_W'(MAX_ROWS) + ADDR_W'(r)) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
  endfunction

endpackage

`default_nettype wire

@@ hdl/pvpc_ram.sv @@
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module pvpc_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

@@ hdl/pvpc_mod.sv @@
// Bit-serial remainder unit that reduces a coordinate modulo a volume size.
`timescale 1ns / 1ps
`default_nettype none

module pvpc_mod import pvpc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire mod_req_t req_i,
  output mod_rsp_t      rsp_o
);

  logic               busy_q;
  logic               done_q;
  logic [STEP_W-1:0]  step_q;
  logic [COORD_W-1:0] num_q;
  logic [COORD_W-1:0] rem_q;
  logic [SIZE_W-1:0]  div_q;
  logic [SIZE_W-1:0]  trial;
  logic [COORD_W-1:0] rem_d;

  // Restoring remainder: shift in one dividend bit, subtract when it fits.
  always_comb begin
    trial = SIZE_W'({rem_q, num_q[COORD_W-1]});
    if (trial >= div_q) begin
      rem_d = COORD_W'(trial - div_q);
    end else begin
      rem_d = COORD_W'(trial);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(COORD_W - 1);
      end else if (busy_q) begin
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q - STEP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.dividend;
      div_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[COORD_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

@@ hdl/periodic_voxel_pore_classifier_core.sv @@
// Top level of the periodic voxel pore classifier: sequencer, counters and mask store.
`timescale 1ns / 1ps
`default_nettype none

// Usage: raise start for one cycle with kind, row, col, slice and mask_value while
// busy is low; the command is taken at that clock edge. A load writes one mask bit,
// a classify reads the eight voxels of the periodic 2x2x2 window below the voxel
// and counts pores and interfaces, and a clear zeroes both counters.
// Each command returns exactly one result: valid_o is high for one cycle with
// voxel_class_o, pore_count_o and interface_count_o, and the receiver must take it
// then, as it cannot stall the block.
// For load and classify, each of the three coordinates goes in turn through the
// shared bit-serial remainder unit; a load then writes its bit, and a classify
// reads the window from the single-port mask memory one voxel per cycle. One
// command is in flight at a time; busy is high until its result is shown, so the
// next command may be accepted in the cycle of that result. The size registers
// are written through cfg_we_i, cfg_idx_i and cfg_data_i; the user must write
// them only while no command is in flight, as the block does not enforce it.
// Reset sets all sizes to 64 and clears both counters; the mask memory is not
// cleared and must be loaded before it is classified.

module periodic_voxel_pore_classifier_core import pvpc_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [KIND_W-1:0]    kind_i,
  input  wire logic [COORD_W-1:0]   row_i,
  input  wire logic [COORD_W-1:0]   col_i,
  input  wire logic [COORD_W-1:0]   slice_i,
  input  wire logic [MASK_W-1:0]    mask_value_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [SIZE_W-1:0]    cfg_data_i,
  output logic                      valid_o,
  output logic [CLASS_W-1:0]        voxel_class_o,
  output logic [COUNT_W-1:0]        pore_count_o,
  output logic [COUNT_W-1:0]        interface_count_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD_GO,
    ST_MOD_WAIT,
    ST_WRITE,
    ST_READ,
    ST_LAST
  } state_e;

  localparam logic [1:0] AXIS_LAST = 2'd2;

  state_e              state_q;
  logic [KIND_W-1:0]   kind_q;
  logic [COORD_W-1:0]  coord_q [3];
  logic                mask_bit_q;
  logic [1:0]          axis_q;
  logic [WIN_W-1:0]    win_q;
  logic [WCOUNT_W-1:0] wcount_q;
  logic                valid_q;
  logic [CLASS_W-1:0]  class_q;
  logic [COUNT_W-1:0]  pore_cnt_q;
  logic [COUNT_W-1:0]  intf_cnt_q;
  logic [SIZE_W-1:0]   rows_q;
  logic [SIZE_W-1:0]   cols_q;
  logic [SIZE_W-1:0]   slices_q;

  logic [SIZE_W-1:0]   axis_size;
  logic [COORD_W-1:0]  row_lo;
  logic [COORD_W-1:0]  col_lo;
  logic [COORD_W-1:0]  slice_lo;
  logic [COORD_W-1:0]  win_row;
  logic [COORD_W-1:0]  win_col;
  logic [COORD_W-1:0]  win_slice;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_addr;
  logic                ram_rdata;
  logic [WCOUNT_W-1:0] wcount_total;
  mod_req_t            mod_req;
  mod_rsp_t            mod_rsp;

  // Coordinate order in coord_q: row, column, slice.
  always_comb begin
    case (axis_q)
      2'd0:    axis_size = rows_q;
      2'd1:    axis_size = cols_q;
      default: axis_size = slices_q;
    endcase
  end

  assign mod_req.start    = (state_q == ST_MOD_GO);
  assign mod_req.dividend = coord_q[axis_q];
  assign mod_req.divisor  = axis_size;

  pvpc_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  assign row_lo   = lower_coord(coord_q[0], rows_q);
  assign col_lo   = lower_coord(coord_q[1], cols_q);
  assign slice_lo = lower_coord(coord_q[2], slices_q);

  // Window member k takes the lower neighbor along row, column and slice by its bits.
  assign win_row   = win_q[0] ? row_lo   : coord_q[0];
  assign win_col   = win_q[1] ? col_lo   : coord_q[1];
  assign win_slice = win_q[2] ? slice_lo : coord_q[2];

  assign ram_we = (state_q == ST_WRITE);

  always_comb begin
    if (state_q == ST_WRITE) begin
      ram_addr = voxel_addr(coord_q[0], coord_q[1], coord_q[2]);
    end else begin
      ram_addr = voxel_addr(win_row, win_col, win_slice);
    end
  end

  pvpc_ram #(
    .WIDTH (1),
    .DEPTH (STORE_DEPTH)
  ) u_mask_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (mask_bit_q),
    .rdata_o (ram_rdata)
  );

  assign wcount_total = wcount_q + WCOUNT_W'(ram_rdata);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q   <= clamp_size(SIZE_W'(64), MAX_ROWS);
      cols_q   <= clamp_size(SIZE_W'(64), MAX_COLS);
      slices_q <= clamp_size(SIZE_W'(64), MAX_SLICES);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROWS:   rows_q   <= clamp_size(cfg_data_i, MAX_ROWS);
        CFG_COLS:   cols_q   <= clamp_size(cfg_data_i, MAX_COLS);
        CFG_SLICES: slices_q <= clamp_size(cfg_data_i, MAX_SLICES);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      axis_q     <= '0;
      win_q      <= '0;
      wcount_q   <= '0;
      valid_q    <= 1'b0;
      class_q    <= CLS_SOLID;
      pore_cnt_q <= '0;
      intf_cnt_q <= '0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          axis_q   <= '0;
          win_q    <= '0;
          wcount_q <= '0;
          if (start) begin
            unique case (kind_i) inside
              KIND_LOAD, KIND_CLASSIFY: begin
                state_q <= ST_MOD_GO;
              end
              KIND_CLEAR: begin
                pore_cnt_q <= '0;
                intf_cnt_q <= '0;
                class_q    <= CLS_SOLID;
                valid_q    <= 1'b1;
              end
              default: begin
                class_q <= CLS_SOLID;
                valid_q <= 1'b1;
              end
            endcase
          end
        end
        ST_MOD_GO: begin
          state_q <= ST_MOD_WAIT;
        end
        ST_MOD_WAIT: begin
          if (mod_rsp.done) begin
            if (axis_q == AXIS_LAST) begin
              state_q <= (kind_q == KIND_LOAD) ? ST_WRITE : ST_READ;
            end else begin
              axis_q  <= axis_q + 2'd1;
              state_q <= ST_MOD_GO;
            end
          end
        end
        ST_WRITE: begin
          class_q <= CLS_SOLID;
          valid_q <= 1'b1;
          state_q <= ST_IDLE;
        end
        ST_READ: begin
          // Read data of the previous window member arrives in the cycle after its address.
          if (win_q != '0) begin
            wcount_q <= wcount_total;
          end
          if (win_q == WIN_W'(WINDOW_CELLS - 1)) begin
            state_q <= ST_LAST;
          end else begin
            win_q <= win_q + WIN_W'(1);
          end
        end
        ST_LAST: begin
          if (wcount_total == WCOUNT_W'(WINDOW_CELLS)) begin
            class_q <= CLS_PORE;
            if (pore_cnt_q != COUNT_MAX) begin
              pore_cnt_q <= pore_cnt_q + COUNT_W'(1);
            end
          end else if (wcount_total != '0) begin
            class_q <= CLS_INTERFACE;
            if (intf_cnt_q != COUNT_MAX) begin
              intf_cnt_q <= intf_cnt_q + COUNT_W'(1);
            end
          end else begin
            class_q <= CLS_SOLID;
          end
          valid_q <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Command payload; coordinates are replaced by their reduced values as they finish.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start) begin
      kind_q     <= kind_i;
      coord_q[0] <= row_i;
      coord_q[1] <= col_i;
      coord_q[2] <= slice_i;
      mask_bit_q <= (mask_value_i != '0);
    end else if (state_q == ST_MOD_WAIT && mod_rsp.done) begin
      coord_q[axis_q] <= mod_rsp.rem;
    end
  end

  assign busy              = (state_q != ST_IDLE);
  assign valid_o           = valid_q;
  assign voxel_class_o     = class_q;
  assign pore_count_o      = pore_cnt_q;
  assign interface_count_o = intf_cnt_q;

`ifndef SYNTHESIS
  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy)
    else $error("result shown while a transaction is still in flight");

  a_long_kinds_go_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (kind_i == KIND_LOAD || kind_i == KIND_CLASSIFY)) |=> busy)
    else $error("load or classify transaction did not start the sequencer");

  a_counters_move_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pore_cnt_q != $past(pore_cnt_q) || intf_cnt_q != $past(intf_cnt_q)) |-> valid_o)
    else $error("counter changed without a result");

  a_pore_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && voxel_class_o == CLS_PORE) |-> (pore_count_o != '0))
    else $error("pore result with a zero pore counter");

  a_mod_only_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_rsp.done |-> (state_q == ST_MOD_WAIT))
    else $error("remainder unit finished outside of its wait state");
`endif

endmodule

`default_nettype wire
